FILE: design/msi_pkg.sv
`timescale 1ns / 1ps
package msi_pkg;

  localparam int QUEUE_DEPTH   = 4;
  localparam int UPDATE_MARGIN = 20;

  localparam logic [1:0] CFG_AXIS_INVERTED = 2'd0;
  localparam logic [1:0] CFG_REFRESH_PERIOD = 2'd1;
  localparam logic [1:0] CFG_MISSED_LIMIT = 2'd2;
  localparam logic [1:0] CFG_CRUISE_MIN_TICKS = 2'd3;

  localparam logic [15:0] RST_REFRESH_PERIOD = 16'd40;
  localparam logic [7:0]  RST_MISSED_LIMIT = 8'd8;
  localparam logic [31:0] RST_CRUISE_MIN_TICKS = 32'd10000;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_PUSH    = 2'd1,
    OP_RESTART = 2'd2,
    OP_NOP     = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]         action;
    logic [31:0]        now;
    logic signed [47:0] seg_start_pos;
    logic signed [47:0] seg_start_speed;
    logic signed [47:0] seg_half_accel;
    logic [31:0]        seg_duration;
    logic signed [47:0] seg_end_pos;
  } in_t;

  typedef struct packed {
    logic signed [47:0] position;
    logic signed [47:0] speed;
    logic               moving;
    logic               cruising;
    logic               direction;
    logic               push_rejected;
    logic               missed;
    logic               fault;
  } out_t;

  typedef struct packed {
    logic signed [47:0] org_pos;
    logic signed [47:0] start_speed;
    logic signed [47:0] acc_half;
    logic [31:0]        duration;
    logic signed [47:0] end_pos;
  } seg_t;

  typedef struct packed {
    op_t op;
    in_t word;
  } cmd_t;

  // saturate to signed 48 bits
  function automatic logic signed [47:0] sat48(input logic signed [81:0] x);
    logic signed [47:0] r;
    if (x[81:47] == '0 || x[81:47] == '1) begin
      r = x[47:0];
    end else if (x[81]) begin
      r = {1'b1, 47'd0};
    end else begin
      r = {1'b0, {47{1'b1}}};
    end
    return r;
  endfunction

endpackage

FILE: design/motion_segment_interpolator.sv
`timescale 1ns / 1ps
// One-axis constant-acceleration segment interpolator. Words pushed in are tick, segment push,
// restart or no-op commands; every word yields exactly one result word. Push, restart, no-op and
// a missed tick go from idle straight to the emit state; a good tick passes the check state first,
// and one that evaluates a segment then runs the serial 49x17 multiply-accumulate unit that forms
// position and speed in 16-bit slices, then the finish state; each segment pulled from the segment
// queue adds a load and a check step. A result that is not popped holds the back end. A two-word
// command queue accepts new words while a result waits to be popped.
module motion_segment_interpolator #(
  parameter int QUEUE_DEPTH   = msi_pkg::QUEUE_DEPTH,
  parameter int UPDATE_MARGIN = msi_pkg::UPDATE_MARGIN
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  input  msi_pkg::in_t  in_word,
  output logic          in_full,
  output logic          out_empty,
  input  logic          out_pop,
  output msi_pkg::out_t out_word,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [31:0]   cfg_wdata
);

  logic          cmd_valid, cmd_take, out_valid;
  msi_pkg::cmd_t cmd;

  msi_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_word  (in_word),
    .in_full  (in_full),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_take (cmd_take)
  );

  msi_exec #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .UPDATE_MARGIN(UPDATE_MARGIN)
  ) u_exec (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_take (cmd_take),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .out_valid(out_valid),
    .out_pop  (out_pop),
    .out_word (out_word)
  );

  assign out_empty = !out_valid;

  a_miss_still: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_word.missed |-> out_word.speed == '0)
    else $error("missed tick with nonzero speed");

  a_idle_still: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_word.moving |-> out_word.speed == '0 && !out_word.cruising)
    else $error("speed or cruising without active segment");

  a_one_flag: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_word.push_rejected |-> !out_word.missed)
    else $error("reject and miss in one word");

endmodule

FILE: design/msi_ram.sv
`timescale 1ns / 1ps
module msi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

FILE: design/msi_front.sv
`timescale 1ns / 1ps
module msi_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_push,
  input  msi_pkg::in_t   in_word,
  output logic           in_full,
  output logic           cmd_valid,
  output msi_pkg::cmd_t  cmd,
  input  logic           cmd_take
);

  msi_pkg::cmd_t ent_r [2];
  logic          wr_r, rd_r;
  logic [1:0]    cnt_r;
  msi_pkg::op_t  op;
  logic          wr_en, rd_en;

  always_comb begin
    unique case (in_word.action)
      msi_pkg::OP_TICK:    op = msi_pkg::OP_TICK;
      msi_pkg::OP_PUSH:    op = msi_pkg::OP_PUSH;
      msi_pkg::OP_RESTART: op = msi_pkg::OP_RESTART;
      default:             op = msi_pkg::OP_NOP;
    endcase
  end

  assign in_full   = (cnt_r == 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = ent_r[rd_r];
  assign wr_en     = in_push && !in_full;
  assign rd_en     = cmd_take && cmd_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ent_r[wr_r] <= '{op: op, word: in_word};
    end
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_en) wr_r <= !wr_r;
      if (rd_en) rd_r <= !rd_r;
      cnt_r <= cnt_r + 2'(wr_en) - 2'(rd_en);
    end
  end

endmodule

FILE: design/msi_exec.sv
`timescale 1ns / 1ps
module msi_exec #(
  parameter int QUEUE_DEPTH   = msi_pkg::QUEUE_DEPTH,
  parameter int UPDATE_MARGIN = msi_pkg::UPDATE_MARGIN
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  input  msi_pkg::cmd_t cmd,
  output logic          cmd_take,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [31:0]   cfg_wdata,
  output logic          out_valid,
  input  logic          out_pop,
  output msi_pkg::out_t out_word
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
  localparam logic [AW:0] DEPTH_W = (AW + 1)'(QUEUE_DEPTH);
  localparam logic [32:0] MARGIN_C = 33'(UPDATE_MARGIN);
  localparam logic [3:0] LAST_STEP = 4'd10;

  typedef enum logic [2:0] {
    S_IDLE, S_CHK, S_LOAD, S_MUL, S_FIN, S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    DST_TT, DST_P, DST_S
  } dst_t;

  state_t             state_r;
  logic [AW-1:0]      head_r;
  logic [CW-1:0]      count_r;
  msi_pkg::seg_t      act_r;
  logic               act_valid_r;
  logic [31:0]        tb_r, prior_r, now_r, t_r;
  logic signed [47:0] held_r, pos_r, spd_r;
  logic [7:0]         miss_r;
  logic               dir_r, fault_r, rej_r, missf_r;
  logic               inv_r;
  logic [15:0]        period_r;
  logic [7:0]         mlimit_r;
  logic [31:0]        cruise_r;
  logic [63:0]        tt_r;
  logic signed [113:0] acc_p_r;
  logic signed [83:0] acc_s_r;
  logic [3:0]         step_r;
  logic signed [65:0] prod_r;
  dst_t               pdst_r;
  logic [5:0]         psh_r;
  logic               pv_r;
  msi_pkg::out_t      out_r;
  logic               out_valid_r;

  msi_pkg::seg_t      ram_q, ram_wd;
  logic               ram_we;
  logic [AW:0]        tail_sum, tail_w;
  logic [AW-1:0]      head_inc;
  logic [31:0]        gap, epoch;
  logic               sane, expire, cruise_now;
  logic [7:0]         miss_inc;
  logic signed [48:0] mul_a;
  logic [15:0]        mul_b;
  dst_t               mul_dst;
  logic [5:0]         mul_sh;
  logic signed [65:0] mul_p;
  logic signed [47:0] pos_sat, spd_sat;

  assign tail_sum = {1'b0, head_r} + (AW + 1)'(count_r);
  assign tail_w   = (tail_sum >= DEPTH_W) ? tail_sum - DEPTH_W : tail_sum;
  assign head_inc = (head_r == LAST) ? '0 : head_r + 1'b1;
  assign gap      = cmd.word.now - prior_r;
  assign sane     = ({1'b0, gap} + MARGIN_C) < {16'd0, period_r, 1'b0};
  assign miss_inc = (miss_r == 8'hFF) ? miss_r : miss_r + 8'd1;
  assign epoch    = now_r - tb_r;
  assign expire   = !act_valid_r || (epoch > act_r.duration);
  assign cruise_now = act_valid_r && (act_r.acc_half == '0) && (act_r.duration > cruise_r);
  assign cmd_take = (state_r == S_IDLE) && cmd_valid;
  assign ram_we   = cmd_take && (cmd.op == msi_pkg::OP_PUSH) && (count_r < DEPTH_C);
  assign ram_wd   = '{org_pos: cmd.word.seg_start_pos,
                      start_speed: cmd.word.seg_start_speed,
                      acc_half: cmd.word.seg_half_accel,
                      duration: cmd.word.seg_duration,
                      end_pos: cmd.word.seg_end_pos};
  assign pos_sat  = msi_pkg::sat48($signed(acc_p_r[113:32]));
  assign spd_sat  = msi_pkg::sat48(82'($signed(acc_s_r[83:16])));
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  msi_ram #(
    .WIDTH($bits(msi_pkg::seg_t)),
    .DEPTH(QUEUE_DEPTH),
    .AW(AW)
  ) u_seg_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(tail_w[AW-1:0]),
    .wdata(ram_wd),
    .raddr(head_r),
    .rdata(ram_q)
  );

  // t*t, then v*t, a*t*t, a*t in 16-bit slices of the unsigned operand
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_dst = DST_TT;
    mul_sh  = '0;
    case (step_r)
      4'd0: begin mul_a = {17'd0, t_r}; mul_b = t_r[15:0]; end
      4'd1: begin mul_a = {17'd0, t_r}; mul_b = t_r[31:16]; mul_sh = 6'd16; end
      4'd2: begin
        mul_a = 49'(act_r.start_speed); mul_b = t_r[15:0];
        mul_dst = DST_P; mul_sh = 6'd16;
      end
      4'd3: begin
        mul_a = 49'(act_r.start_speed); mul_b = t_r[31:16];
        mul_dst = DST_P; mul_sh = 6'd32;
      end
      4'd4: begin mul_a = 49'(act_r.acc_half); mul_b = tt_r[15:0]; mul_dst = DST_P; end
      4'd5: begin
        mul_a = 49'(act_r.acc_half); mul_b = tt_r[31:16];
        mul_dst = DST_P; mul_sh = 6'd16;
      end
      4'd6: begin
        mul_a = 49'(act_r.acc_half); mul_b = tt_r[47:32];
        mul_dst = DST_P; mul_sh = 6'd32;
      end
      4'd7: begin
        mul_a = 49'(act_r.acc_half); mul_b = tt_r[63:48];
        mul_dst = DST_P; mul_sh = 6'd48;
      end
      4'd8: begin
        mul_a = 49'(act_r.acc_half); mul_b = t_r[15:0];
        mul_dst = DST_S; mul_sh = 6'd1;
      end
      4'd9: begin
        mul_a = 49'(act_r.acc_half); mul_b = t_r[31:16];
        mul_dst = DST_S; mul_sh = 6'd17;
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * $signed({1'b0, mul_b});

  always_ff @(posedge clk) begin
    if (pv_r) begin
      case (pdst_r)
        DST_TT:  tt_r <= tt_r + (64'(prod_r[47:0]) << psh_r);
        DST_P:   acc_p_r <= acc_p_r + (114'(prod_r) <<< psh_r);
        default: acc_s_r <= acc_s_r + (84'(prod_r) <<< psh_r);
      endcase
    end

    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      act_r       <= '0;
      act_valid_r <= 1'b0;
      tb_r        <= '0;
      prior_r     <= '0;
      held_r      <= '0;
      miss_r      <= '0;
      dir_r       <= 1'b0;
      fault_r     <= 1'b0;
      inv_r       <= 1'b0;
      period_r    <= msi_pkg::RST_REFRESH_PERIOD;
      mlimit_r    <= msi_pkg::RST_MISSED_LIMIT;
      cruise_r    <= msi_pkg::RST_CRUISE_MIN_TICKS;
      pv_r        <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          msi_pkg::CFG_AXIS_INVERTED:  inv_r <= cfg_wdata[0];
          msi_pkg::CFG_REFRESH_PERIOD: period_r <= cfg_wdata[15:0];
          msi_pkg::CFG_MISSED_LIMIT:   mlimit_r <= cfg_wdata[7:0];
          default:                     cruise_r <= cfg_wdata;
        endcase
      end

      if (out_pop && out_valid_r && state_r != S_EMIT) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (cmd_valid) begin
            spd_r   <= '0;
            rej_r   <= (cmd.op == msi_pkg::OP_PUSH) && (count_r >= DEPTH_C);
            missf_r <= (cmd.op == msi_pkg::OP_TICK) && !sane;
            pos_r   <= (cmd.op == msi_pkg::OP_RESTART) ? cmd.word.seg_start_pos : held_r;
            state_r <= (cmd.op == msi_pkg::OP_TICK && sane) ? S_CHK : S_EMIT;
            unique case (cmd.op)
              msi_pkg::OP_PUSH: begin
                if (count_r < DEPTH_C) count_r <= count_r + 1'b1;
              end
              msi_pkg::OP_RESTART: begin
                head_r      <= '0;
                count_r     <= '0;
                act_valid_r <= 1'b0;
                tb_r        <= cmd.word.now;
                held_r      <= cmd.word.seg_start_pos;
                miss_r      <= '0;
                fault_r     <= 1'b0;
              end
              msi_pkg::OP_TICK: begin
                prior_r <= cmd.word.now;
                now_r   <= cmd.word.now;
                if (!sane) begin
                  miss_r <= miss_inc;
                  if (miss_inc > mlimit_r) fault_r <= 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        S_CHK: begin
          if (expire) begin
            if (act_valid_r) begin
              tb_r        <= tb_r + act_r.duration;
              pos_r       <= act_r.end_pos;
              act_valid_r <= 1'b0;
            end
            if (count_r == '0) begin
              held_r  <= act_valid_r ? act_r.end_pos : pos_r;
              spd_r   <= '0;
              miss_r  <= '0;
              state_r <= S_EMIT;
            end else begin
              state_r <= S_LOAD;
            end
          end else begin
            t_r     <= epoch;
            tt_r    <= '0;
            acc_p_r <= 114'(act_r.org_pos) <<< 32;
            acc_s_r <= 84'(act_r.start_speed) <<< 16;
            step_r  <= '0;
            state_r <= S_MUL;
          end
        end
        S_LOAD: begin
          act_r       <= ram_q;
          act_valid_r <= 1'b1;
          head_r      <= head_inc;
          count_r     <= count_r - 1'b1;
          pos_r       <= ram_q.org_pos;
          state_r     <= S_CHK;
        end
        S_MUL: begin
          pv_r   <= (step_r != LAST_STEP);
          prod_r <= mul_p;
          pdst_r <= mul_dst;
          psh_r  <= mul_sh;
          step_r <= step_r + 4'd1;
          if (step_r == LAST_STEP) state_r <= S_FIN;
        end
        S_FIN: begin
          held_r <= pos_sat;
          pos_r  <= pos_sat;
          spd_r  <= spd_sat;
          miss_r <= '0;
          if (spd_sat != '0) dir_r <= inv_r ? !spd_sat[47] : spd_sat[47];
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid_r || out_pop) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end

    if (state_r == S_EMIT && (!out_valid_r || out_pop)) begin
      out_r <= '{position: pos_r, speed: spd_r, moving: act_valid_r,
                 cruising: cruise_now, direction: dir_r, push_rejected: rej_r,
                 missed: missf_r, fault: fault_r};
    end
  end

endmodule

FILE: verif/msi_checker.sv
`timescale 1ns / 1ps
module msi_checker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  input  msi_pkg::in_t  in_word,
  input  logic          in_full,
  input  logic          out_empty,
  input  logic          out_pop,
  input  msi_pkg::out_t out_word,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [31:0]   cfg_wdata,
  output int            errors,
  output int            pending,
  output int            results_seen
);
  import msi_pkg::*;

  localparam logic signed [127:0] MAX48 = 128'sh7FFF_FFFF_FFFF;
  localparam logic signed [127:0] MIN48 = -128'sh8000_0000_0000;

  logic        inv_r;
  logic [15:0] period_r;
  logic [7:0]  limit_r;
  logic [31:0] cruise_r;

  seg_t        seg_q [QUEUE_DEPTH];
  int          seg_head, seg_cnt;
  seg_t        cur_seg;
  logic        cur_valid;
  logic [31:0] base_t, last_tick;
  logic [47:0] hold_pos;
  logic [7:0]  miss_cnt;
  logic        dir_r, fault_r;

  out_t        expected_words [$];

  function automatic logic [47:0] clamp48(input logic signed [127:0] x);
    if (x > MAX48) return MAX48[47:0];
    if (x < MIN48) return MIN48[47:0];
    return x[47:0];
  endfunction

  function automatic out_t make_word(input logic [47:0] p, input logic [47:0] s,
                                     input logic rej, input logic miss);
    out_t o;
    o.position      = p;
    o.speed         = s;
    o.moving        = cur_valid;
    o.cruising      = cur_valid && cur_seg.acc_half == '0 && cur_seg.duration > cruise_r;
    o.direction     = dir_r;
    o.push_rejected = rej;
    o.missed        = miss;
    o.fault         = fault_r;
    return o;
  endfunction

  task automatic clear_state();
    inv_r = 1'b0; period_r = RST_REFRESH_PERIOD; limit_r = RST_MISSED_LIMIT;
    cruise_r = RST_CRUISE_MIN_TICKS;
    seg_head = 0; seg_cnt = 0; cur_seg = '0; cur_valid = 1'b0;
    base_t = '0; last_tick = '0; hold_pos = '0; miss_cnt = '0; dir_r = 1'b0;
    fault_r = 1'b0;
    expected_words.delete();
  endtask

  task automatic predict_word(input in_t w);
    logic [31:0]             gap, epoch;
    logic [47:0]             pos, spd;
    int                      lim;
    logic signed [127:0]     p0, v0, a0, tt, acc, sv;
    case (op_t'(w.action))
      OP_PUSH: begin
        if (seg_cnt >= QUEUE_DEPTH) begin
          expected_words.push_back(make_word(hold_pos, '0, 1'b1, 1'b0));
        end else begin
          seg_q[(seg_head + seg_cnt) % QUEUE_DEPTH] = '{w.seg_start_pos, w.seg_start_speed,
              w.seg_half_accel, w.seg_duration, w.seg_end_pos};
          seg_cnt++;
          expected_words.push_back(make_word(hold_pos, '0, 1'b0, 1'b0));
        end
      end
      OP_RESTART: begin
        seg_head = 0; seg_cnt = 0; cur_valid = 1'b0;
        base_t = w.now; hold_pos = w.seg_start_pos; miss_cnt = '0; fault_r = 1'b0;
        expected_words.push_back(make_word(hold_pos, '0, 1'b0, 1'b0));
      end
      OP_NOP: expected_words.push_back(make_word(hold_pos, '0, 1'b0, 1'b0));
      default: begin
        gap = w.now - last_tick;
        last_tick = w.now;
        lim = 2 * int'(period_r) - UPDATE_MARGIN;
        if (!(lim > 0 && longint'(gap) < longint'(lim))) begin
          if (miss_cnt != 8'hFF) miss_cnt++;
          if (miss_cnt > limit_r) fault_r = 1'b1;
          expected_words.push_back(make_word(hold_pos, '0, 1'b0, 1'b1));
        end else begin
          epoch = w.now - base_t;
          pos = hold_pos;
          while (!cur_valid || epoch > cur_seg.duration) begin
            if (cur_valid) begin
              base_t += cur_seg.duration;
              pos = cur_seg.end_pos;
              cur_valid = 1'b0;
            end
            if (seg_cnt == 0) break;
            cur_seg = seg_q[seg_head];
            cur_valid = 1'b1;
            seg_head = (seg_head + 1) % QUEUE_DEPTH;
            seg_cnt--;
            pos = cur_seg.org_pos;
            epoch = w.now - base_t;
          end
          spd = '0;
          if (cur_valid) begin
            p0 = cur_seg.org_pos;
            v0 = cur_seg.start_speed;
            a0 = cur_seg.acc_half;
            tt = $signed({96'd0, epoch});
            acc = (p0 <<< 32) + ((v0 * tt) <<< 16) + a0 * (tt * tt);
            pos = clamp48(acc >>> 32);
            sv = (v0 <<< 16) + ((a0 * tt) <<< 1);
            spd = clamp48(sv >>> 16);
          end
          if (spd != '0) dir_r = inv_r ? !spd[47] : spd[47];
          hold_pos = pos;
          miss_cnt = '0;
          expected_words.push_back(make_word(pos, spd, 1'b0, 1'b0));
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_state();
      errors = 0;
      results_seen = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_AXIS_INVERTED:    inv_r = cfg_wdata[0];
          CFG_REFRESH_PERIOD:   period_r = cfg_wdata[15:0];
          CFG_MISSED_LIMIT:     limit_r = cfg_wdata[7:0];
          CFG_CRUISE_MIN_TICKS: cruise_r = cfg_wdata;
          default: ;
        endcase
      end
      if (out_pop && !out_empty) begin
        results_seen++;
        if (expected_words.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result word %h", out_word);
        end else begin
          out_t e;
          e = expected_words.pop_front();
          if (out_word !== e) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp pos %h spd %h flags %b, got pos %h spd %h flags %b",
                       e.position, e.speed, e[5:0], out_word.position, out_word.speed,
                       out_word[5:0]);
          end
        end
      end
      if (in_push && !in_full) predict_word(in_word);
    end
    pending = expected_words.size();
  end

endmodule

FILE: verif/tb_motion_segment_interpolator.sv
`timescale 1ns / 1ps
module tb_motion_segment_interpolator;
  import msi_pkg::*;

  localparam int STALL_LIMIT = 20000;

  logic  clk = 0;
  logic  rst_n = 0;
  logic  in_push = 0;
  in_t   in_word = '0;
  logic  in_full, out_empty;
  logic  out_pop = 0;
  out_t  out_word;
  logic  cfg_we = 0;
  logic [1:0]  cfg_index = CFG_AXIS_INVERTED;
  logic [31:0] cfg_wdata = 0;

  int    errors, pending, results_seen;
  int    words_sent = 0;
  int    quiet_cycles = 0;
  int    leftover;
  logic  idle_en = 1;
  int    pop_hold = 0;
  logic [31:0] now_t;
  logic [15:0] period_mirror;

  always #2 clk = ~clk;

  motion_segment_interpolator uut (
    .clk, .rst_n, .in_push, .in_word, .in_full, .out_empty, .out_pop, .out_word,
    .cfg_we, .cfg_index, .cfg_wdata
  );

  msi_checker chk (
    .clk, .rst_n, .in_push, .in_word, .in_full, .out_empty, .out_pop, .out_word,
    .cfg_we, .cfg_index, .cfg_wdata, .errors, .pending, .results_seen
  );

  // receiver stall bursts
  always @(posedge clk) begin
    if (pop_hold > 0) begin
      pop_hold <= pop_hold - 1;
      out_pop <= 0;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      pop_hold <= $urandom_range(0, 7);
      out_pop <= 0;
    end else begin
      out_pop <= 1;
    end
  end

  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty) || !rst_n) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic [47:0] rand48();
    case ($urandom_range(0, 9))
      0: return 48'h7FFF_FFFF_FFFF;
      1: return 48'h8000_0000_0000;
      2: return 48'h0;
      3: return {48{1'b1}};
      4, 5: return 48'({$urandom(), $urandom()});
      default: return {{18{1'b0}}, 30'($urandom())} - 48'h2000_0000;
    endcase
  endfunction

  function automatic in_t rand_word();
    logic [287:0] r;
    r = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
         $urandom(), $urandom()};
    return r[$bits(in_t)-1:0];
  endfunction

  task automatic send(input in_t w);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_push <= 0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_push <= 1;
    in_word <= w;
    do @(posedge clk); while (in_full);
    words_sent++;
  endtask

  task automatic send_restart();
    in_t w;
    w = '0;
    w.action = OP_RESTART;
    w.now = now_t;
    w.seg_start_pos = rand48();
    send(w);
  endtask

  task automatic send_segment(input int dur_max);
    in_t w;
    w.action = OP_PUSH;
    w.now = $urandom();
    w.seg_start_pos = rand48();
    w.seg_start_speed = rand48();
    w.seg_half_accel = ($urandom_range(0, 3) == 0) ? 48'd0 : rand48();
    w.seg_duration = ($urandom_range(0, 15) == 0) ? $urandom() : $urandom_range(0, dur_max);
    w.seg_end_pos = rand48();
    send(w);
  endtask

  task automatic send_tick(input logic late);
    in_t w;
    int lim;
    lim = 2 * int'(period_mirror) - UPDATE_MARGIN;
    if (!late && lim > 0) now_t += $urandom_range(0, lim - 1);
    else now_t += (lim > 0 ? lim : 0) + $urandom_range(0, 1000);
    w = rand_word();
    w.action = OP_TICK;
    w.now = now_t;
    send(w);
  endtask

  task automatic settle();
    in_push <= 0;
    @(posedge clk);
    wait (pending == 0);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_regs(input logic inv, input logic [15:0] per, input logic [7:0] lim,
                            input logic [31:0] cruise);
    cfg_we <= 1; cfg_index <= CFG_AXIS_INVERTED; cfg_wdata <= {31'd0, inv};
    @(posedge clk);
    cfg_index <= CFG_REFRESH_PERIOD; cfg_wdata <= {16'd0, per};
    @(posedge clk);
    cfg_index <= CFG_MISSED_LIMIT; cfg_wdata <= {24'd0, lim};
    @(posedge clk);
    cfg_index <= CFG_CRUISE_MIN_TICKS; cfg_wdata <= cruise;
    @(posedge clk);
    cfg_we <= 0;
    period_mirror = per;
  endtask

  task automatic run_phase(input int n_words);
    int target;
    int dmax;
    in_t w;
    target = words_sent + n_words;
    while (words_sent < target) begin
      dmax = 3 * int'(period_mirror);
      if ($urandom_range(0, 9) == 0) begin
        w = rand_word();
        send(w);
      end else begin
        if ($urandom_range(0, 2) == 0) send_restart();
        repeat ($urandom_range(1, 5)) send_segment(dmax);
        for (int i = $urandom_range(3, 14); i > 0; i--) begin
          send_tick($urandom_range(0, 11) == 0);
          if ($urandom_range(0, 7) == 0) send_segment(dmax);
        end
      end
    end
  endtask

  initial begin
    in_t w;
    now_t = 0;
    period_mirror = RST_REFRESH_PERIOD;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: defaults, extremes, queue full, miss and fault, cruising, unused code
    send_tick(0);
    w = '0; w.action = OP_RESTART; w.now = 32'hFFFF_FFF0; w.seg_start_pos = 48'h7FFF_FFFF_FFFF;
    now_t = 32'hFFFF_FFF0;
    send(w);
    w = '0; w.action = OP_PUSH; w.seg_start_pos = 48'h7FFF_FFFF_FFFF;
    w.seg_start_speed = 48'h7FFF_FFFF_FFFF; w.seg_half_accel = 48'h7FFF_FFFF_FFFF;
    w.seg_duration = 30; w.seg_end_pos = 48'h8000_0000_0000;
    send(w);
    w.seg_start_pos = 48'h8000_0000_0000; w.seg_start_speed = 48'h8000_0000_0000;
    w.seg_half_accel = 48'h8000_0000_0000; w.seg_duration = 32'hFFFF_FFFF;
    send(w);
    w.seg_half_accel = 0; w.seg_start_speed = 48'h100; w.seg_duration = 20000;
    send(w);
    w.seg_duration = 0;
    send(w);
    send(w);
    for (int i = 0; i < 6; i++) send_tick(0);
    for (int i = 0; i < 10; i++) send_tick(1);
    send_tick(0);
    w = '1; w.action = OP_NOP;
    send(w);
    send_restart();
    settle();

    write_regs(1, 16'hFFFF, 8'd0, 32'd0);
    run_phase(380);
    settle();
    write_regs(0, 16'd1, 8'hFF, 32'hFFFF_FFFF);
    run_phase(120);
    settle();
    write_regs(1, 16'd11, 8'd2, 32'd50);
    run_phase(400);
    settle();
    write_regs($urandom_range(0, 1), 16'($urandom_range(11, 5000)), 8'($urandom()),
               $urandom_range(0, 3000));
    run_phase(400);
    settle();
    write_regs(0, RST_REFRESH_PERIOD, RST_MISSED_LIMIT, RST_CRUISE_MIN_TICKS);
    run_phase(300);
    idle_en = 0;
    run_phase(300);

    in_push <= 0;
    @(posedge clk);
    wait (pending == 0);
    leftover = 0;
    while (leftover < 200) begin
      @(posedge clk);
      leftover++;
    end
    $display("Covered %0d input words and %0d result words over six register settings,",
             words_sent, results_seen);
    $display("including restarts, full-queue pushes, late refreshes and saturation.");
    if (errors == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

FILE: motion_segment_interpolator.f
design/msi_pkg.sv
design/msi_ram.sv
design/msi_front.sv
design/msi_exec.sv
design/motion_segment_interpolator.sv
verif/msi_checker.sv
verif/tb_motion_segment_interpolator.sv
